// ----- hw/rtl/rrw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rrw_pkg;

   localparam int WINDOW      = 16;
   localparam int SEQ_BITS    = 16;
   localparam int MAX_RESULTS = 18;
   localparam int REF_W       = 16;
   localparam int ACK_W       = 16;
   localparam int IDX_W       = $clog2(WINDOW);
   localparam int CNT_W       = $clog2(MAX_RESULTS);

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_HANDSHAKE = 2'd0;
   localparam mode_type MODE_RECEIVING = 2'd1;
   localparam mode_type MODE_IDLE      = 2'd2;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_DELIVER = 2'd0;
   localparam kind_type KIND_ACK     = 2'd1;
   localparam kind_type KIND_END     = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic load_in;       // capture request transaction
      logic set_recv;      // handshake done, start receiving
      logic set_idle;      // transfer ended
      logic store;         // park packet in its slot
      logic deliver_in;    // emit captured packet, advance
      logic deliver_slot;  // emit head slot, advance
      logic emit_ack;      // emit cumulative ack (last)
      logic emit_end;      // emit end marker (last)
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic mode_hs;
      logic mode_recv;
      logic ok;
      logic hs;
      logic is_end;
      logic dist_zero;
      logic dist_in_win;
      logic head_valid;
      logic cnt_room;
      logic out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

// ----- hw/rtl/reorder_receive_window.sv -----
// The first result is registered after the request is captured and evaluated; a good
//   packet that is not the expected one, with an empty head slot, adds a drain check.
// A silent packet returns to waiting after evaluation, a lone ack or end result comes
//   from its own state, and a good packet while receiving is delivered and drained to a
//   last check. Stalls on rsp_tready hold the sequencer; the next request is taken once
//   the last result sits in the output register. Reset (synchronous): handshake mode,
//   next expected 0, slot valids cleared at once; slot payloads need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module reorder_receive_window (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [15:0] seq_num, [31:16] payload_ref
   input  wire logic [2:0]  req_tuser,   // [0] checksum_ok, [1] is_handshake, [2] is_end
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [15:0] out_ref, [31:16] ack_num
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast    // last result of this transaction
);

   rrw_pkg::dp_cmd_type cmd;
   rrw_pkg::dp_sts_type sts;
   rrw_pkg::kind_type   rsp_kind;
   logic [rrw_pkg::REF_W-1:0] rsp_ref;
   logic [rrw_pkg::ACK_W-1:0] rsp_ack;

   // sequencer: one transaction at a time, one result per cycle unless rsp_tready stalls
   rrw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // window state, slot store and result register
   rrw_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .in_seq     (req_tdata[rrw_pkg::SEQ_BITS-1:0]),
      .in_ok      (req_tuser[0]),
      .in_hs      (req_tuser[1]),
      .in_end     (req_tuser[2]),
      .in_ref     (req_tdata[31:16]),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_kind   (rsp_kind),
      .rsp_ref    (rsp_ref),
      .rsp_ack    (rsp_ack),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {rsp_ack, rsp_ref};
   assign rsp_tuser = rsp_kind;

endmodule

`default_nettype wire

// ----- hw/rtl/rrw_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rrw_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire rrw_pkg::dp_sts_type sts,
   output rrw_pkg::dp_cmd_type     cmd
);

   typedef enum logic [5:0] {
      S_WAIT    = 6'b000001,
      S_EVAL    = 6'b000010,
      S_DELIVER = 6'b000100,
      S_DRAIN   = 6'b001000,
      S_ACK     = 6'b010000,
      S_END     = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_WAIT);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_WAIT: begin
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            if (sts.mode_hs) begin
               if (sts.ok) begin
                  cmd.set_recv = sts.hs;
                  state_in     = S_ACK;
               end else begin
                  state_in = S_WAIT;
               end
            end else if (!sts.mode_recv) begin
               state_in = S_WAIT;
            end else if (!sts.ok) begin
               state_in = S_ACK;
            end else if (sts.dist_zero) begin
               state_in = sts.is_end ? S_END : S_DELIVER;
            end else begin
               // ahead packets with the end mark are dropped
               cmd.store = sts.dist_in_win && !sts.is_end;
               state_in  = S_DRAIN;
            end
         end
         S_DELIVER: begin
            if (sts.out_free) begin
               cmd.deliver_in = 1'b1;
               state_in       = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (sts.head_valid && sts.cnt_room) begin
               cmd.deliver_slot = sts.out_free;
            end else begin
               state_in = S_ACK;
            end
         end
         S_ACK: begin
            if (sts.out_free) begin
               cmd.emit_ack = 1'b1;
               state_in     = S_WAIT;
            end
         end
         S_END: begin
            if (sts.out_free) begin
               cmd.emit_end = 1'b1;
               cmd.set_idle = 1'b1;
               state_in     = S_WAIT;
            end
         end
         default: begin
            state_in = S_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/rrw_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rrw_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [rrw_pkg::SEQ_BITS-1:0] in_seq,
   input  wire logic                        in_ok,
   input  wire logic                        in_hs,
   input  wire logic                        in_end,
   input  wire logic [rrw_pkg::REF_W-1:0]   in_ref,
   input  wire rrw_pkg::dp_cmd_type         cmd,
   output rrw_pkg::dp_sts_type              sts,
   input  wire logic                        rsp_tready,
   output logic                             rsp_tvalid,
   output rrw_pkg::kind_type                rsp_kind,
   output logic [rrw_pkg::REF_W-1:0]        rsp_ref,
   output logic [rrw_pkg::ACK_W-1:0]        rsp_ack,
   output logic                             rsp_last
);

   // captured transaction
   logic [rrw_pkg::SEQ_BITS-1:0] seq_ff;
   logic                         ok_ff;
   logic                         hs_ff;
   logic                         end_ff;
   logic [rrw_pkg::REF_W-1:0]    ref_ff;

   // receiver state
   rrw_pkg::mode_type            mode_ff;
   logic [rrw_pkg::SEQ_BITS-1:0] next_exp_ff;
   logic [rrw_pkg::IDX_W-1:0]    head_ff;
   logic [rrw_pkg::WINDOW-1:0]   valid_ff;
   logic [rrw_pkg::REF_W-1:0]    slot_ref_ff [rrw_pkg::WINDOW];
   logic [rrw_pkg::CNT_W-1:0]    cnt_ff;

   // result register
   logic                         out_valid_ff;
   rrw_pkg::kind_type            out_kind_ff;
   logic [rrw_pkg::REF_W-1:0]    out_ref_ff;
   logic [rrw_pkg::ACK_W-1:0]    out_ack_ff;
   logic                         out_last_ff;

   logic [rrw_pkg::SEQ_BITS-1:0] seq_gap;
   logic [rrw_pkg::IDX_W:0]      idx_sum;
   logic [rrw_pkg::IDX_W-1:0]    store_idx;
   logic [rrw_pkg::IDX_W-1:0]    head_next;
   logic                         advance;
   logic                         out_free;

   assign seq_gap = seq_ff - next_exp_ff;
   // seq_gap < WINDOW here, so one compare-subtract wraps the ring index
   assign idx_sum = {1'b0, head_ff} + {1'b0, seq_gap[rrw_pkg::IDX_W-1:0]};
   assign store_idx = (idx_sum >= (rrw_pkg::IDX_W+1)'(rrw_pkg::WINDOW))
                    ? rrw_pkg::IDX_W'(idx_sum - (rrw_pkg::IDX_W+1)'(rrw_pkg::WINDOW))
                    : idx_sum[rrw_pkg::IDX_W-1:0];
   assign head_next = (head_ff == rrw_pkg::IDX_W'(rrw_pkg::WINDOW - 1))
                    ? '0 : head_ff + 1'b1;
   assign advance  = cmd.deliver_in || cmd.deliver_slot;
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      sts.mode_hs     = (mode_ff == rrw_pkg::MODE_HANDSHAKE);
      sts.mode_recv   = (mode_ff == rrw_pkg::MODE_RECEIVING);
      sts.ok          = ok_ff;
      sts.hs          = hs_ff;
      sts.is_end      = end_ff;
      sts.dist_zero   = (seq_gap == '0);
      sts.dist_in_win = (seq_gap < rrw_pkg::SEQ_BITS'(rrw_pkg::WINDOW));
      sts.head_valid  = valid_ff[head_ff];
      sts.cnt_room    = (cnt_ff < rrw_pkg::CNT_W'(rrw_pkg::MAX_RESULTS - 1));
      sts.out_free    = out_free;
   end

   // input capture and slot payloads: no reset needed
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         seq_ff <= in_seq;
         ok_ff  <= in_ok;
         hs_ff  <= in_hs;
         end_ff <= in_end;
         ref_ff <= in_ref;
      end
      if (cmd.store) begin
         slot_ref_ff[store_idx] <= ref_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= rrw_pkg::MODE_HANDSHAKE;
         next_exp_ff <= '0;
         head_ff     <= '0;
         valid_ff    <= '0;
         cnt_ff      <= '0;
      end else begin
         if (cmd.set_recv) begin
            mode_ff <= rrw_pkg::MODE_RECEIVING;
         end else if (cmd.set_idle) begin
            mode_ff <= rrw_pkg::MODE_IDLE;
         end
         if (cmd.store) begin
            valid_ff[store_idx] <= 1'b1;
         end
         if (advance) begin
            valid_ff[head_ff] <= 1'b0;
            head_ff           <= head_next;
            next_exp_ff       <= next_exp_ff + 1'b1;
         end
         if (cmd.load_in) begin
            cnt_ff <= '0;
         end else if (advance) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance || cmd.emit_ack || cmd.emit_end) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.deliver_in) begin
         out_kind_ff <= rrw_pkg::KIND_DELIVER;
         out_ref_ff  <= ref_ff;
         out_ack_ff  <= '0;
         out_last_ff <= 1'b0;
      end else if (cmd.deliver_slot) begin
         out_kind_ff <= rrw_pkg::KIND_DELIVER;
         out_ref_ff  <= slot_ref_ff[head_ff];
         out_ack_ff  <= '0;
         out_last_ff <= 1'b0;
      end else if (cmd.emit_ack) begin
         out_kind_ff <= rrw_pkg::KIND_ACK;
         out_ref_ff  <= '0;
         out_ack_ff  <= rrw_pkg::ACK_W'(next_exp_ff);
         out_last_ff <= 1'b1;
      end else if (cmd.emit_end) begin
         out_kind_ff <= rrw_pkg::KIND_END;
         out_ref_ff  <= '0;
         out_ack_ff  <= '0;
         out_last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_kind   = out_kind_ff;
   assign rsp_ref    = out_ref_ff;
   assign rsp_ack    = out_ack_ff;
   assign rsp_last   = out_last_ff;

endmodule

`default_nettype wire
